/* src/scd_pkg.sv */
// Shared types and constants for the sector cache directory.
package scd_pkg;
	localparam int SLOTS = 32;
	localparam int SW = $clog2(SLOTS);

	typedef enum logic [1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_REMOVE = 2'd2,
		OP_FLUSH  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		K_ACCESS = 2'd0,
		K_WB     = 2'd1,
		K_DONE   = 2'd2
	} kind_t;

	// controller -> datapath
	typedef struct packed {
		logic          load;      // latch request
		logic          lookup;    // register tag match result
		logic          sweep_step;// clear accessed at hand, advance hand
		logic          install;   // write victim/free slot
		logic          hit_touch; // set accessed (and dirty on write) at hit slot
		logic          remove;    // invalidate hit slot
		logic          flush_step;// invalidate slot at flush index, advance
		logic          flush_clr; // reset flush index
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic          is_flush;
		logic          is_remove;
		logic          hit;
		logic          has_free;
		logic          hand_acc;   // accessed bit at clock hand
		logic          flush_dirty;// flush index slot valid and dirty
		logic          flush_end;  // flush index at last slot
	} sts_t;
endpackage

/* src/scd_datapath.sv */
// Slot directory storage, tag match, free search and clock hand.
module scd_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  scd_pkg::cmd_t             cmd,
	input  logic [1:0]                in_op,
	input  logic [31:0]               in_sector,
	output scd_pkg::sts_t             sts,
	output logic [scd_pkg::SW-1:0]    hit_slot,
	output logic [scd_pkg::SW-1:0]    hand,
	output logic [scd_pkg::SW-1:0]    free_slot,
	output logic [scd_pkg::SW-1:0]    flush_idx,
	output logic                      victim_dirty,
	output logic [31:0]               victim_tag,
	output logic [31:0]               flush_tag,
	output logic [1:0]                op
);
	localparam int N = scd_pkg::SLOTS;
	localparam int W = scd_pkg::SW;

	logic [N-1:0]  valid_q, acc_q, dirty_q;
	logic [31:0]   tag_q [N];
	logic [31:0]   sector_q;
	logic [1:0]    op_q;
	logic          hit_q, has_free_q;
	logic [W-1:0]  hit_slot_q, free_q, hand_q, fidx_q;
	logic [W-1:0]  match_idx, free_idx, tgt;
	logic          match_any, free_any;

	always_comb begin
		match_any = 1'b0;
		match_idx = '0;
		free_any  = 1'b0;
		free_idx  = '0;
		for (int i = N-1; i >= 0; i--) begin
			if (valid_q[i] && tag_q[i] == sector_q) begin
				match_any = 1'b1;
				match_idx = W'(i);
			end
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = W'(i);
			end
		end
	end

	assign tgt = has_free_q ? free_q : hand_q;

	always_ff @(posedge clk) begin
		if (cmd.load)
			sector_q <= in_sector;
		if (cmd.lookup) begin
			hit_slot_q <= match_idx;
			free_q     <= free_idx;
		end
		if (cmd.install)
			tag_q[tgt] <= sector_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			acc_q      <= '0;
			dirty_q    <= '0;
			hand_q     <= '0;
			fidx_q     <= '0;
			op_q       <= '0;
			hit_q      <= 1'b0;
			has_free_q <= 1'b0;
		end else begin
			if (cmd.load)
				op_q <= in_op;
			if (cmd.lookup) begin
				hit_q      <= match_any;
				has_free_q <= free_any;
			end
			if (cmd.sweep_step) begin
				acc_q[hand_q] <= 1'b0;
				hand_q <= (hand_q == W'(N-1)) ? '0 : hand_q + 1'b1;
			end
			if (cmd.install) begin
				valid_q[tgt] <= 1'b1;
				acc_q[tgt]   <= 1'b1;
				dirty_q[tgt] <= (op_q == scd_pkg::OP_WRITE);
				if (!has_free_q)
					hand_q <= (hand_q == W'(N-1)) ? '0 : hand_q + 1'b1;
			end
			if (cmd.hit_touch) begin
				acc_q[hit_slot_q] <= 1'b1;
				if (op_q == scd_pkg::OP_WRITE)
					dirty_q[hit_slot_q] <= 1'b1;
			end
			if (cmd.remove)
				valid_q[hit_slot_q] <= 1'b0;
			if (cmd.flush_clr)
				fidx_q <= '0;
			if (cmd.flush_step) begin
				valid_q[fidx_q] <= 1'b0;
				// index parks on the last slot
				if (fidx_q != W'(N-1))
					fidx_q <= fidx_q + 1'b1;
			end
		end
	end

	assign sts.is_flush    = (op_q == scd_pkg::OP_FLUSH);
	assign sts.is_remove   = (op_q == scd_pkg::OP_REMOVE);
	assign sts.hit         = hit_q;
	assign sts.has_free    = has_free_q;
	assign sts.hand_acc    = acc_q[hand_q];
	assign sts.flush_dirty = valid_q[fidx_q] & dirty_q[fidx_q];
	assign sts.flush_end   = (fidx_q == W'(N-1));

	assign hit_slot     = hit_slot_q;
	assign hand         = hand_q;
	assign free_slot    = free_q;
	assign flush_idx    = fidx_q;
	assign victim_dirty = dirty_q[hand_q];
	assign victim_tag   = tag_q[hand_q];
	assign flush_tag    = tag_q[fidx_q];
	assign op           = op_q;
endmodule

/* src/scd_ctrl.sv */
// Request sequencer: lookup, sweep, install, flush walk and result register.
module scd_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [47:0]               m_tdata,
	output logic                      m_tlast,
	output scd_pkg::cmd_t             cmd,
	input  scd_pkg::sts_t             sts,
	input  logic [scd_pkg::SW-1:0]    hit_slot,
	input  logic [scd_pkg::SW-1:0]    hand,
	input  logic [scd_pkg::SW-1:0]    free_slot,
	input  logic [scd_pkg::SW-1:0]    flush_idx,
	input  logic                      victim_dirty,
	input  logic [31:0]               victim_tag,
	input  logic [31:0]               flush_tag,
	input  logic [1:0]                op
);
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_LOOK   = 6'b000010,
		ST_DEC    = 6'b000100,
		ST_SWEEP  = 6'b001000,
		ST_FLUSH  = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	state_t       state_q, state_d;
	logic [47:0]  data_q, data_d;
	logic         last_q, last_d, load_out, ovalid_q;

	function automatic logic [47:0] pack(scd_pkg::kind_t k, logic h, logic [4:0] s,
		logic f, logic wv, logic [31:0] ws);
		pack = {6'd0, ws, wv, f, s, h, k};
	endfunction

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		data_d   = data_q;
		last_d   = last_q;
		load_out = 1'b0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
				if (s_tvalid)
					state_d = ST_LOOK;
			end
			ST_LOOK: begin
				cmd.lookup    = 1'b1;
				cmd.flush_clr = 1'b1;
				state_d = sts.is_flush ? ST_FLUSH : ST_DEC;
			end
			ST_DEC: begin
				if (sts.is_remove) begin
					cmd.remove = sts.hit;
					data_d = pack(scd_pkg::K_ACCESS, sts.hit, sts.hit ? 5'(hit_slot) : 5'd0,
						1'b0, 1'b0, 32'd0);
					last_d = 1'b1; load_out = 1'b1; state_d = ST_OUT;
				end else if (sts.hit) begin
					cmd.hit_touch = 1'b1;
					data_d = pack(scd_pkg::K_ACCESS, 1'b1, 5'(hit_slot), 1'b0, 1'b0, 32'd0);
					last_d = 1'b1; load_out = 1'b1; state_d = ST_OUT;
				end else if (sts.has_free) begin
					cmd.install = 1'b1;
					data_d = pack(scd_pkg::K_ACCESS, 1'b0, 5'(free_slot),
						op == scd_pkg::OP_READ, 1'b0, 32'd0);
					last_d = 1'b1; load_out = 1'b1; state_d = ST_OUT;
				end else
					state_d = ST_SWEEP;
			end
			ST_SWEEP: begin
				// one slot per cycle until an unaccessed victim is under the hand
				if (sts.hand_acc)
					cmd.sweep_step = 1'b1;
				else begin
					cmd.install = 1'b1;
					data_d = pack(scd_pkg::K_ACCESS, 1'b0, 5'(hand), op == scd_pkg::OP_READ,
						victim_dirty, victim_dirty ? victim_tag : 32'd0);
					last_d = 1'b1; load_out = 1'b1; state_d = ST_OUT;
				end
			end
			ST_FLUSH: begin
				if (!ovalid_q || m_tready) begin
					if (sts.flush_dirty) begin
						data_d = pack(scd_pkg::K_WB, 1'b0, 5'(flush_idx), 1'b0, 1'b1, flush_tag);
						last_d = 1'b0; load_out = 1'b1;
						cmd.flush_step = 1'b1;
					end else if (sts.flush_end) begin
						cmd.flush_step = 1'b1;
						data_d = pack(scd_pkg::K_DONE, 1'b0, 5'd0, 1'b0, 1'b0, 32'd0);
						last_d = 1'b1; load_out = 1'b1; state_d = ST_OUT;
					end else
						cmd.flush_step = 1'b1;
				end
				// a dirty last slot: the index stays put, the next flush step sees it clean and emits done
			end
			ST_OUT: begin
				if (!ovalid_q || m_tready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
			if (load_out)
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk)
		data_q <= data_d;

	assign m_tvalid = ovalid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;
endmodule

/* src/sector_cache_directory_clock.sv */
// Sector cache directory, top level.
// Fully associative directory of 32 slots with lowest-free allocation and
// clock replacement. One request is handled at a time. A hit, remove or
// allocation into a free slot goes through the lookup and decode states
// before the result word is registered; a clock sweep first steps the hand
// past each accessed slot, clearing its accessed bit.
// A flush walks every slot one per cycle while the output is not stalled,
// emitting a writeback word per dirty slot and a done word.
// Tag match and free search are parallel over all slots; the sweep and the
// flush walk are the sequential parts.
module sector_cache_directory_clock (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // operation[1:0], sector[33:2], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // kind[1:0], hit[2], slot[7:3], fill_needed[8],
	                              // writeback_valid[9], writeback_sector[41:10], zero
	output logic        m_tlast
);
	scd_pkg::cmd_t           cmd;
	scd_pkg::sts_t           sts;
	logic [scd_pkg::SW-1:0]  hit_slot, hand, free_slot, flush_idx;
	logic                    victim_dirty;
	logic [31:0]             victim_tag, flush_tag;
	logic [1:0]              op;

	scd_datapath u_dp (
		.clk, .arst_n, .cmd,
		.in_op(s_tdata[1:0]), .in_sector(s_tdata[33:2]),
		.sts, .hit_slot, .hand, .free_slot, .flush_idx,
		.victim_dirty, .victim_tag, .flush_tag, .op
	);

	scd_ctrl u_ctrl (
		.clk, .arst_n, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast,
		.cmd, .sts, .hit_slot, .hand, .free_slot, .flush_idx,
		.victim_dirty, .victim_tag, .flush_tag, .op
	);
endmodule

/* src/scd_checker.sv */
// Port-level checks for the sector cache directory.
module scd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word dropped under stall");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("bad result kind");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != 2'd1 |-> m_tlast)
		else $error("access or done word without last");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");
endmodule

bind sector_cache_directory_clock scd_checker u_chk (.*);
